### rtl/acs_pkg.sv
// Shared types, constants and decode functions for the audio container sniffer.
// Used by acs_frame_div and audio_container_sniffer_unit; depends on nothing.
package acs_pkg;

  typedef logic [31:0][7:0] hdr_t;
  typedef logic [7:0][7:0]  ogg_t;

  localparam logic [4:0] FmtNone     = 5'd0;
  localparam logic [4:0] FmtWave     = 5'd1;
  localparam logic [4:0] FmtRmid     = 5'd2;
  localparam logic [4:0] FmtAu       = 5'd3;
  localparam logic [4:0] FmtAiff     = 5'd4;
  localparam logic [4:0] FmtFlac     = 5'd5;
  localparam logic [4:0] FmtApe      = 5'd6;
  localparam logic [4:0] FmtTta      = 5'd7;
  localparam logic [4:0] FmtWavpack  = 5'd8;
  localparam logic [4:0] FmtMpc      = 5'd9;
  localparam logic [4:0] FmtMidi     = 5'd10;
  localparam logic [4:0] FmtAmr      = 5'd11;
  localparam logic [4:0] FmtAmrWb    = 5'd12;
  localparam logic [4:0] FmtMp4      = 5'd13;
  localparam logic [4:0] FmtAsf      = 5'd14;
  localparam logic [4:0] FmtReal     = 5'd15;
  localparam logic [4:0] FmtVorbis   = 5'd16;
  localparam logic [4:0] FmtOpus     = 5'd17;
  localparam logic [4:0] FmtOggFlac  = 5'd18;
  localparam logic [4:0] FmtAdts     = 5'd19;
  localparam logic [4:0] FmtMpegBase = 5'd19;

  localparam logic [127:0] AsfGuid = 128'h3026b2758e66cf11a6d900aa0062ce6c;

  localparam logic [0:2][0:13][8:0] KbpsV1 = '{
    '{9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd288, 9'd320,
      9'd352, 9'd384, 9'd416, 9'd448},
    '{9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192,
      9'd224, 9'd256, 9'd320, 9'd384},
    '{9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd160,
      9'd192, 9'd224, 9'd256, 9'd320}};
  localparam logic [0:1][0:13][8:0] KbpsV2 = '{
    '{9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160,
      9'd176, 9'd192, 9'd224, 9'd256},
    '{9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd144, 9'd160}};

  function automatic logic match_sig(hdr_t h, int unsigned off, logic [127:0] sig,
                                     int unsigned len);
    logic m;
    m = 1'b1;
    for (int unsigned i = 0; i < 16; i++) begin
      if (i < len) begin
        if (h[off + i] != sig[(len - 1 - i) * 8 +: 8]) begin
          m = 1'b0;
        end
      end
    end
    return m;
  endfunction

  function automatic logic [12:0] adts_len(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                           logic [7:0] b3, logic [7:0] b4, logic [7:0] b5);
    logic [12:0] n;
    logic [12:0] least;
    n = {b3[1:0], b4, b5[7:5]};
    least = b1[0] ? 13'd7 : 13'd9;
    if (b0 != 8'hff || (b1 & 8'hf6) != 8'hf0 || b2[5:2] >= 4'd13 || n < least) begin
      return 13'd0;
    end
    return n;
  endfunction

  function automatic logic mpeg_ok(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    return b0 == 8'hff && b1[7:5] == 3'b111 && b1[4:3] != 2'd1 && b1[2:1] != 2'd0 &&
           b2[3:2] != 2'd3 && b2[7:4] != 4'd0 && b2[7:4] != 4'd15;
  endfunction

  function automatic logic [8:0] mpeg_kbps(logic [1:0] version, logic [1:0] lcode,
                                           logic [3:0] bidx);
    logic [3:0] k;
    k = bidx - 4'd1;
    if (version == 2'd3) begin
      return KbpsV1[2'd3 - lcode][k];
    end
    return KbpsV2[(lcode == 2'd3) ? 1'b0 : 1'b1][k];
  endfunction

  function automatic logic [63:0] accept_mask(logic [4:0] fmt);
    logic [63:0] m;
    m = '0;
    case (fmt)
      FmtWave:    m = 64'h1e;
      FmtRmid:    m = 64'h20;
      FmtAu:      m = 64'hc0;
      FmtAiff:    m = 64'h700;
      FmtFlac:    m = 64'h1800;
      FmtApe:     m = 64'h6000;
      FmtTta:     m = 64'h8000;
      FmtWavpack: m = 64'h10000;
      FmtMpc:     m = 64'he0000;
      FmtMidi:    m = 64'h700000;
      FmtAmr:     m = 64'h800000;
      FmtAmrWb:   m = 64'h1800000;
      FmtMp4:     m = 64'h1fe000000;
      FmtAsf:     m = 64'he00000000;
      FmtReal:    m = 64'hf000000000;
      FmtVorbis:  m = 64'h30000000000;
      FmtOpus:    m = 64'h70000000000;
      FmtOggFlac: m = 64'h30000000000;
      FmtAdts:    m = 64'h180000000000;
      5'd20:      m = 64'h000f200000000000;
      5'd21:      m = 64'h000f400000000000;
      5'd22:      m = 64'h001f800000000000;
      default:    m = '0;
    endcase
    return m;
  endfunction

endpackage

### rtl/acs_frame_div.sv
// MPEG audio frame length unit: bitrate lookup, one multiply, then a
// restoring divide by the sample rate, one quotient bit per cycle.
// Depends on acs_pkg.
module acs_frame_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [7:0]  hdr1_i,
  input  logic [7:0]  hdr2_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [12:0] len_o
);

  typedef enum logic [1:0] {DV_IDLE, DV_MUL, DV_DIV, DV_DONE} div_state_e;

  div_state_e  state_q;
  logic [8:0]  kbps_q;
  logic [17:0] mul_k_q;
  logic [15:0] hz_q;
  logic        layer1_q;
  logic        pad_q;
  logic [15:0] rem_q;
  logic [11:0] low_q;
  logic [11:0] quo_q;
  logic [3:0]  cnt_q;

  logic [1:0]  version;
  logic [1:0]  lcode;
  logic [15:0] hz_base;
  logic [25:0] prod;
  logic [16:0] shifted;
  logic        qbit;
  logic [16:0] rem_sub;
  logic [12:0] sum;

  assign version = hdr1_i[4:3];
  assign lcode   = hdr1_i[2:1];

  always_comb begin
    case (hdr2_i[3:2])
      2'd1:    hz_base = 16'd48000;
      2'd2:    hz_base = 16'd32000;
      default: hz_base = 16'd44100;
    endcase
  end

  assign prod    = 26'(mul_k_q * kbps_q);
  assign shifted = {rem_q, low_q[11]};
  assign qbit    = shifted >= {1'b0, hz_q};
  assign rem_sub = shifted - {1'b0, hz_q};
  assign sum     = {1'b0, quo_q} + {12'd0, pad_q};
  assign len_o   = layer1_q ? {sum[10:0], 2'b00} : sum;
  assign busy_o  = state_q != DV_IDLE;
  assign done_o  = state_q == DV_DONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      kbps_q <= '0;
      mul_k_q <= '0;
      hz_q <= '0;
      layer1_q <= 1'b0;
      pad_q <= 1'b0;
      rem_q <= '0;
      low_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
    end else begin
      case (state_q)
        DV_IDLE: begin
          if (start_i) begin
            kbps_q <= acs_pkg::mpeg_kbps(version, lcode, hdr2_i[7:4]);
            if (lcode == 2'd3) begin
              mul_k_q <= 18'd12000;
            end else if (lcode == 2'd1 && version != 2'd3) begin
              mul_k_q <= 18'd72000;
            end else begin
              mul_k_q <= 18'd144000;
            end
            if (version == 2'd3) begin
              hz_q <= hz_base;
            end else if (version == 2'd2) begin
              hz_q <= hz_base >> 1;
            end else begin
              hz_q <= hz_base >> 2;
            end
            layer1_q <= lcode == 2'd3;
            pad_q <= hdr2_i[1];
            state_q <= DV_MUL;
          end
        end
        DV_MUL: begin
          rem_q <= {2'b00, prod[25:12]};
          low_q <= prod[11:0];
          quo_q <= '0;
          cnt_q <= '0;
          state_q <= DV_DIV;
        end
        DV_DIV: begin
          rem_q <= qbit ? rem_sub[15:0] : shifted[15:0];
          low_q <= {low_q[10:0], 1'b0};
          quo_q <= {quo_q[10:0], qbit};
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd11) begin
            state_q <= DV_DONE;
          end
        end
        DV_DONE: begin
          state_q <= DV_IDLE;
        end
        default: begin
          state_q <= DV_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/audio_container_sniffer_unit.sv
// Audio container sniffer: takes file header bytes and classifies the container.
// Takes one byte per cycle unless stalled: input stalls during the frame length divide
// after a third byte that forms a valid MPEG header, and from the last byte until
// the result is taken, which may wait on the shared divider for a second frame.
// Reset clears all stream state and the registers; after each result the
// stream state returns to reset while the registers keep their values.
module audio_container_sniffer_unit #(
  parameter int unsigned BUFFER_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  detected_format_o,
  output logic        suggest_rename_o
);

  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned XW = ((CW > 13) ? CW : 13) + 2;

  typedef enum logic [2:0] {ST_RUN, ST_CHECK, ST_WAIT, ST_FINAL, ST_OUT} state_e;

  state_e          state_q;
  logic [63:0]     file_size_q;
  logic [5:0]      ext_q;
  acs_pkg::hdr_t   hdr_q;
  acs_pkg::ogg_t   ogg_q;
  logic [6:0][7:0] adts2_q;
  logic [3:0][7:0] mpeg2_q;
  logic [CW-1:0]   count_q;
  logic [12:0]     adts_n_q;
  logic [11:0]     mpeg_n_q;
  logic [12:0]     mpeg_full_q;
  logic [8:0]      ogg_off_q;
  logic            mpeg2_ok_q;
  logic [12:0]     mpeg2_n_q;
  logic            out_valid_q;
  logic [4:0]      fmt_q;
  logic            rename_q;

  logic        acc;
  logic        wr;
  logic [XW-1:0] cx;
  logic        adts_hit;
  logic        mpeg_hit;
  logic        ogg_hit;
  logic [XW-1:0] adts_d;
  logic [XW-1:0] mpeg_d;
  logic [XW-1:0] ogg_d;
  logic        m1ok;
  logic        need2;
  logic        div_start;
  logic        div_busy;
  logic        div_done;
  logic [12:0] div_len;
  logic [7:0]  div_h1;
  logic [7:0]  div_h2;
  logic [4:0]  fmt;
  logic [12:0] adts_n2;
  logic [63:0] mask;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_RUN) || div_busy;
  assign acc         = in_valid_i && !in_stall_o;
  assign wr          = acc && (count_q < CW'(BUFFER_BYTES));
  assign cx          = XW'(count_q);

  assign adts_d   = cx - XW'(adts_n_q);
  assign mpeg_d   = cx - XW'(mpeg_n_q);
  assign ogg_d    = cx - XW'(ogg_off_q);
  assign adts_hit = adts_n_q != 13'd0 && cx >= XW'(adts_n_q) && adts_d < XW'(7);
  assign mpeg_hit = mpeg_n_q != 12'd0 && cx >= XW'(mpeg_n_q) && mpeg_d < XW'(4);
  assign ogg_hit  = ogg_off_q != 9'd0 && cx >= XW'(ogg_off_q) && ogg_d < XW'(8);

  assign m1ok  = mpeg_full_q != 13'd0 && XW'(mpeg_full_q) + XW'(4) <= cx;
  assign need2 = m1ok && acs_pkg::mpeg_ok(mpeg2_q[0], mpeg2_q[1], mpeg2_q[2]) &&
                 mpeg2_q[1][4:1] == hdr_q[1][4:1] && mpeg2_q[2][3:2] == hdr_q[2][3:2];

  assign div_h1    = (state_q == ST_CHECK) ? mpeg2_q[1] : hdr_q[1];
  assign div_h2    = (state_q == ST_CHECK) ? mpeg2_q[2] : data_byte_i;
  assign div_start = (state_q == ST_CHECK && need2) ||
                     (state_q == ST_RUN && wr && !last_byte_i && count_q == CW'(2) &&
                      acs_pkg::mpeg_ok(hdr_q[0], hdr_q[1], data_byte_i));

  acs_frame_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hdr1_i  (div_h1),
    .hdr2_i  (div_h2),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .len_o   (div_len)
  );

  assign adts_n2 = acs_pkg::adts_len(adts2_q[0], adts2_q[1], adts2_q[2], adts2_q[3],
                                     adts2_q[4], adts2_q[5]);

  always_comb begin
    logic riff;
    logic [31:0] w0;
    logic [31:0] w4;
    riff = acs_pkg::match_sig(hdr_q, 0, "RIFF", 4) && cx >= XW'(4);
    w0 = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]};
    w4 = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
    fmt = acs_pkg::FmtNone;
    if (cx < XW'(16)) begin
      fmt = acs_pkg::FmtNone;
    end else if ((riff || acs_pkg::match_sig(hdr_q, 0, "RF64", 4) ||
                  acs_pkg::match_sig(hdr_q, 0, "BW64", 4)) &&
                 acs_pkg::match_sig(hdr_q, 8, "WAVE", 4)) begin
      fmt = acs_pkg::FmtWave;
    end else if (riff && acs_pkg::match_sig(hdr_q, 8, "RMID", 4)) begin
      fmt = acs_pkg::FmtRmid;
    end else if (acs_pkg::match_sig(hdr_q, 0, ".snd", 4) && w4 >= 32'd24 &&
                 {32'd0, w4} <= file_size_q) begin
      fmt = acs_pkg::FmtAu;
    end else if (acs_pkg::match_sig(hdr_q, 0, "FORM", 4) &&
                 (acs_pkg::match_sig(hdr_q, 8, "AIFF", 4) ||
                  acs_pkg::match_sig(hdr_q, 8, "AIFC", 4))) begin
      fmt = acs_pkg::FmtAiff;
    end else if (acs_pkg::match_sig(hdr_q, 0, "fLaC", 4) && hdr_q[4][6:0] == 7'd0 &&
                 hdr_q[5] == 8'd0 && hdr_q[6] == 8'd0 && hdr_q[7] == 8'd34 &&
                 file_size_q >= 64'd42) begin
      fmt = acs_pkg::FmtFlac;
    end else if (acs_pkg::match_sig(hdr_q, 0, "MAC ", 4) && cx >= XW'(32)) begin
      fmt = acs_pkg::FmtApe;
    end else if (acs_pkg::match_sig(hdr_q, 0, "TTA1", 4)) begin
      fmt = acs_pkg::FmtTta;
    end else if (acs_pkg::match_sig(hdr_q, 0, "wvpk", 4) && cx >= XW'(32)) begin
      fmt = acs_pkg::FmtWavpack;
    end else if (acs_pkg::match_sig(hdr_q, 0, "MPCK", 4) ||
                 acs_pkg::match_sig(hdr_q, 0, "MP+", 3)) begin
      fmt = acs_pkg::FmtMpc;
    end else if (acs_pkg::match_sig(hdr_q, 0, "MThd", 4) && w4 == 32'd6) begin
      fmt = acs_pkg::FmtMidi;
    end else if (acs_pkg::match_sig(hdr_q, 0, "#!AMR\n", 6)) begin
      fmt = acs_pkg::FmtAmr;
    end else if (acs_pkg::match_sig(hdr_q, 0, "#!AMR-WB\n", 9)) begin
      fmt = acs_pkg::FmtAmrWb;
    end else if (acs_pkg::match_sig(hdr_q, 4, "ftyp", 4) && w0 >= 32'd16 &&
                 {32'd0, w0} <= file_size_q) begin
      fmt = acs_pkg::FmtMp4;
    end else if (acs_pkg::match_sig(hdr_q, 0, acs_pkg::AsfGuid, 16)) begin
      fmt = acs_pkg::FmtAsf;
    end else if (acs_pkg::match_sig(hdr_q, 0, ".RMF", 4)) begin
      fmt = acs_pkg::FmtReal;
    end else if (acs_pkg::match_sig(hdr_q, 0, "OggS", 4) && hdr_q[4] == 8'd0 &&
                 cx >= XW'(28)) begin
      if (XW'(ogg_off_q) + XW'(7) <= cx && ogg_q[0] == 8'h01 && ogg_q[1] == "v" &&
          ogg_q[2] == "o" && ogg_q[3] == "r" && ogg_q[4] == "b" && ogg_q[5] == "i" &&
          ogg_q[6] == "s") begin
        fmt = acs_pkg::FmtVorbis;
      end else if (XW'(ogg_off_q) + XW'(8) <= cx && ogg_q[0] == "O" && ogg_q[1] == "p" &&
                   ogg_q[2] == "u" && ogg_q[3] == "s" && ogg_q[4] == "H" &&
                   ogg_q[5] == "e" && ogg_q[6] == "a" && ogg_q[7] == "d") begin
        fmt = acs_pkg::FmtOpus;
      end else if (XW'(ogg_off_q) + XW'(5) <= cx && ogg_q[0] == 8'h7f &&
                   ogg_q[1] == "F" && ogg_q[2] == "L" && ogg_q[3] == "A" &&
                   ogg_q[4] == "C") begin
        fmt = acs_pkg::FmtOggFlac;
      end else begin
        fmt = acs_pkg::FmtNone;
      end
    end else if (adts_n_q != 13'd0 && XW'(adts_n_q) + XW'(7) <= cx && adts_n2 != 13'd0 &&
                 XW'(adts_n2) <= cx - XW'(adts_n_q) &&
                 hdr_q[2][7:2] == adts2_q[2][7:2]) begin
      fmt = acs_pkg::FmtAdts;
    end else if (m1ok && mpeg2_ok_q && XW'(mpeg2_n_q) <= cx - XW'(mpeg_full_q)) begin
      fmt = acs_pkg::FmtMpegBase + 5'(3'd4 - {1'b0, hdr_q[1][2:1]});
    end
  end

  assign mask = acs_pkg::accept_mask(fmt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      file_size_q <= '0;
      ext_q <= '0;
      hdr_q <= '0;
      ogg_q <= '0;
      adts2_q <= '0;
      mpeg2_q <= '0;
      count_q <= '0;
      adts_n_q <= '0;
      mpeg_n_q <= '0;
      mpeg_full_q <= '0;
      ogg_off_q <= '0;
      mpeg2_ok_q <= 1'b0;
      mpeg2_n_q <= '0;
      out_valid_q <= 1'b0;
      fmt_q <= '0;
      rename_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i) begin
          ext_q <= cfg_data_i[5:0];
        end else begin
          file_size_q <= cfg_data_i;
        end
      end
      case (state_q)
        ST_RUN: begin
          if (wr) begin
            if (count_q < CW'(32)) begin
              hdr_q[count_q[4:0]] <= data_byte_i;
            end
            if (count_q == CW'(5)) begin
              adts_n_q <= acs_pkg::adts_len(hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3],
                                            hdr_q[4], data_byte_i);
            end
            if (count_q == CW'(26)) begin
              ogg_off_q <= 9'd27 + {1'b0, data_byte_i};
            end
            if (adts_hit) begin
              adts2_q[adts_d[2:0]] <= data_byte_i;
            end
            if (mpeg_hit) begin
              mpeg2_q[mpeg_d[1:0]] <= data_byte_i;
            end
            if (ogg_hit) begin
              ogg_q[ogg_d[2:0]] <= data_byte_i;
            end
            count_q <= count_q + CW'(1);
          end
          if (div_done) begin
            mpeg_full_q <= (div_len >= 13'd4) ? div_len : 13'd0;
            mpeg_n_q <= (div_len >= 13'd4) ? div_len[11:0] : 12'd0;
          end
          if (acc && last_byte_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          mpeg2_ok_q <= 1'b0;
          state_q <= need2 ? ST_WAIT : ST_FINAL;
        end
        ST_WAIT: begin
          if (div_done) begin
            mpeg2_ok_q <= div_len >= 13'd4;
            mpeg2_n_q <= div_len;
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          fmt_q <= fmt;
          rename_q <= (fmt != acs_pkg::FmtNone) && !mask[ext_q];
          out_valid_q <= 1'b1;
          hdr_q <= '0;
          ogg_q <= '0;
          adts2_q <= '0;
          mpeg2_q <= '0;
          count_q <= '0;
          adts_n_q <= '0;
          mpeg_n_q <= '0;
          mpeg_full_q <= '0;
          ogg_off_q <= '0;
          mpeg2_ok_q <= 1'b0;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q <= ST_RUN;
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign detected_format_o = fmt_q;
  assign suggest_rename_o  = rename_q;

endmodule

### verif/testbench.sv
// Self-checking testbench for audio_container_sniffer_unit: streams crafted and random
// header buffers, predicts or looks up each classification and checks every result in order.
// Depends on acs_pkg and the RTL of audio_container_sniffer_unit only.
`timescale 1ns / 100ps

module testbench;
  import acs_pkg::*;

  localparam int unsigned BufBytes = 4096;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned TailCycles = 24;
  localparam int unsigned HoldCycles = 400;

  typedef enum int {
    KNoise, KWave, KRmid, KAu, KAiff, KFlac, KApe, KTta, KWavpack, KMpc, KMidi, KAmr,
    KAmrWb, KMp4, KAsf, KReal, KVorbis, KOpus, KOggFlac, KOggBad, KAdts, KMpeg, KMpeg3,
    KNumKinds
  } kind_e;

  typedef struct packed {
    logic [4:0] fmt;
    logic       ren;
  } verdict_t;

  typedef struct {
    kind_e       kind;
    int unsigned len;
    logic [63:0] fs;
    logic [5:0]  ext;
    bit          typed;
    logic [4:0]  fmt;
    bit          ren;
  } probe_t;

  localparam int unsigned KbpsOne [3][14] = '{
    '{32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
    '{32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
    '{32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320}};
  localparam int unsigned KbpsTwo [2][14] = '{
    '{32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
    '{8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}};
  localparam int unsigned RatesHz [3] = '{44100, 48000, 32000};
  localparam logic [127:0] GuidAsf = 128'h3026b2758e66cf11a6d900aa0062ce6c;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [4:0]  detected_format_o;
  logic        suggest_rename_o;

  audio_container_sniffer_unit #(.BUFFER_BYTES(BufBytes)) dut (.*);

  // Predictor state.
  logic [7:0]  hdr [32];
  logic [7:0]  ogg_pl [8];
  logic [7:0]  adts_nxt [7];
  logic [7:0]  mpeg_nxt [4];
  int unsigned taken, adts_first, mpeg_first, ogg_off;
  logic [63:0] cur_size;
  logic [5:0]  cur_ext;

  verdict_t    verdict_q [$];
  logic [7:0]  file_q [$];
  probe_t      probes [25];

  int unsigned cycles, mismatches, bytes_sent, files_sent, results_seen, reg_writes;
  int unsigned snd_idle, rcv_idle, hold_seq, hold_seen, hold_left;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               verdict_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic void clear_stream();
    for (int i = 0; i < 32; i++) hdr[i] = '0;
    for (int i = 0; i < 8; i++) ogg_pl[i] = '0;
    for (int i = 0; i < 7; i++) adts_nxt[i] = '0;
    for (int i = 0; i < 4; i++) mpeg_nxt[i] = '0;
    taken = 0;
    adts_first = 0;
    mpeg_first = 0;
    ogg_off = 0;
  endfunction

  function automatic int unsigned adts_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                             logic [7:0] b3, logic [7:0] b4, logic [7:0] b5);
    int unsigned n;
    n = {b3[1:0], b4, b5[7:5]};
    if (b0 != 8'hff || (b1 & 8'hf6) != 8'hf0 || b2[5:2] >= 13) return 0;
    return (n >= (b1[0] ? 7 : 9)) ? n : 0;
  endfunction

  function automatic int unsigned mpeg_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                             output int unsigned ident,
                                             output int unsigned layer);
    int unsigned ver, rate, bidx, kbps, hz, pad, n;
    ident = 0;
    layer = 4 - b1[2:1];
    ver = b1[4:3];
    rate = b2[3:2];
    bidx = b2[7:4];
    pad = b2[1];
    if (b0 != 8'hff || b1[7:5] != 3'b111) return 0;
    if (ver == 1 || layer == 4 || rate == 3 || bidx == 0 || bidx == 15) return 0;
    kbps = (ver == 3) ? KbpsOne[layer - 1][bidx - 1] : KbpsTwo[(layer == 1) ? 0 : 1][bidx - 1];
    hz = RatesHz[rate] / ((ver == 3) ? 1 : (ver == 2) ? 2 : 4);
    if (layer == 1) begin
      n = (12000 * kbps / hz + pad) * 4;
    end else begin
      n = (((layer == 3 && ver != 3) ? 72000 : 144000) * kbps) / hz + pad;
    end
    ident = (ver << 8) | (layer << 4) | rate;
    return (n >= 4) ? n : 0;
  endfunction

  function automatic bit sig_at(int unsigned off, string s);
    if (off + s.len() > taken || off + s.len() > 32) return 0;
    for (int i = 0; i < s.len(); i++) if (hdr[off + i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic bit ogg_is(string s);
    for (int i = 0; i < s.len(); i++) if (ogg_pl[i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic logic [63:0] word_at(int unsigned p);
    return {32'd0, hdr[p], hdr[p + 1], hdr[p + 2], hdr[p + 3]};
  endfunction

  function automatic logic [4:0] classify(int unsigned c);
    int unsigned n, n2, id1, id2, l1, l2;
    if (c < 16) return FmtNone;
    if ((sig_at(0, "RIFF") || sig_at(0, "RF64") || sig_at(0, "BW64")) && sig_at(8, "WAVE"))
      return FmtWave;
    if (sig_at(0, "RIFF") && sig_at(8, "RMID")) return FmtRmid;
    if (sig_at(0, ".snd") && word_at(4) >= 24 && word_at(4) <= cur_size) return FmtAu;
    if (sig_at(0, "FORM") && (sig_at(8, "AIFF") || sig_at(8, "AIFC"))) return FmtAiff;
    if (sig_at(0, "fLaC") && hdr[4][6:0] == 0 && hdr[5] == 0 && hdr[6] == 0 && hdr[7] == 34 &&
        cur_size >= 42) return FmtFlac;
    if (sig_at(0, "MAC ") && c >= 32) return FmtApe;
    if (sig_at(0, "TTA1")) return FmtTta;
    if (sig_at(0, "wvpk") && c >= 32) return FmtWavpack;
    if (sig_at(0, "MPCK") || sig_at(0, "MP+")) return FmtMpc;
    if (sig_at(0, "MThd") && word_at(4) == 6) return FmtMidi;
    if (sig_at(0, "#!AMR\n")) return FmtAmr;
    if (sig_at(0, "#!AMR-WB\n")) return FmtAmrWb;
    if (sig_at(4, "ftyp") && word_at(0) >= 16 && word_at(0) <= cur_size) return FmtMp4;
    n = 1;
    for (int i = 0; i < 16; i++) if (hdr[i] != GuidAsf[127 - 8 * i -: 8]) n = 0;
    if (n != 0) return FmtAsf;
    if (sig_at(0, ".RMF")) return FmtReal;
    if (sig_at(0, "OggS") && hdr[4] == 0 && c >= 28) begin
      if (ogg_off + 7 <= c && ogg_is("\001vorbis")) return FmtVorbis;
      if (ogg_off + 8 <= c && ogg_is("OpusHead")) return FmtOpus;
      if (ogg_off + 5 <= c && ogg_is("\177FLAC")) return FmtOggFlac;
      return FmtNone;
    end
    n = adts_first;
    if (n != 0 && n <= c && n + 7 <= c) begin
      n2 = adts_frame(adts_nxt[0], adts_nxt[1], adts_nxt[2], adts_nxt[3], adts_nxt[4],
                      adts_nxt[5]);
      if (n2 != 0 && n2 <= c - n && hdr[2][7:2] == adts_nxt[2][7:2]) return FmtAdts;
    end
    n = mpeg_frame(hdr[0], hdr[1], hdr[2], id1, l1);
    if (n != 0 && n <= c && n + 4 <= c) begin
      n2 = mpeg_frame(mpeg_nxt[0], mpeg_nxt[1], mpeg_nxt[2], id2, l2);
      if (n2 != 0 && n2 <= c - n && id1 == id2) return FmtMpegBase + 5'(l1);
    end
    return FmtNone;
  endfunction

  function automatic bit suffix_fits(logic [4:0] f, logic [5:0] e);
    int unsigned lo, hi;
    lo = 64;
    hi = 0;
    case (f)
      FmtWave:    begin lo = 1;  hi = 4;  end
      FmtRmid:    begin lo = 5;  hi = 5;  end
      FmtAu:      begin lo = 6;  hi = 7;  end
      FmtAiff:    begin lo = 8;  hi = 10; end
      FmtFlac:    begin lo = 11; hi = 12; end
      FmtApe:     begin lo = 13; hi = 14; end
      FmtTta:     begin lo = 15; hi = 15; end
      FmtWavpack: begin lo = 16; hi = 16; end
      FmtMpc:     begin lo = 17; hi = 19; end
      FmtMidi:    begin lo = 20; hi = 22; end
      FmtAmr:     begin lo = 23; hi = 23; end
      FmtAmrWb:   begin lo = 23; hi = 24; end
      FmtMp4:     begin lo = 25; hi = 32; end
      FmtAsf:     begin lo = 33; hi = 35; end
      FmtReal:    begin lo = 36; hi = 39; end
      FmtVorbis:  begin lo = 40; hi = 41; end
      FmtOpus:    begin lo = 40; hi = 42; end
      FmtOggFlac: begin lo = 40; hi = 41; end
      FmtAdts:    begin lo = 43; hi = 44; end
      FmtMpegBase + 5'd1: begin lo = 45; hi = 45; end
      FmtMpegBase + 5'd2: begin lo = 46; hi = 46; end
      FmtMpegBase + 5'd3: begin lo = 47; hi = 52; end
      default:    begin lo = 64; hi = 0; end
    endcase
    return (e >= lo && e <= hi) || (f > FmtMpegBase && e >= 48 && e <= 51);
  endfunction

  function automatic bit sniff_byte(logic [7:0] d, bit last, output verdict_t v);
    int unsigned pos, id, ly;
    v = '0;
    if (taken < BufBytes) begin
      pos = taken;
      if (pos < 32) hdr[pos] = d;
      if (pos == 2) mpeg_first = mpeg_frame(hdr[0], hdr[1], hdr[2], id, ly) & 12'hfff;
      if (pos == 5) adts_first = adts_frame(hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5]);
      if (pos == 26) ogg_off = 27 + d;
      if (adts_first != 0 && pos >= adts_first && pos < adts_first + 7)
        adts_nxt[pos - adts_first] = d;
      if (mpeg_first != 0 && pos >= mpeg_first && pos < mpeg_first + 4)
        mpeg_nxt[pos - mpeg_first] = d;
      if (ogg_off != 0 && pos >= ogg_off && pos < ogg_off + 8) ogg_pl[pos - ogg_off] = d;
      taken = pos + 1;
    end
    if (!last) return 0;
    v.fmt = classify(taken);
    v.ren = (v.fmt != FmtNone) && !suffix_fits(v.fmt, cur_ext);
    clear_stream();
    return 1;
  endfunction

  function automatic void put_str(int unsigned off, string s);
    for (int i = 0; i < s.len(); i++) file_q[off + i] = s[i];
  endfunction

  function automatic void put_word(int unsigned off, logic [31:0] w);
    for (int i = 0; i < 4; i++) file_q[off + i] = w[31 - 8 * i -: 8];
  endfunction

  function automatic logic [31:0] size_field(int unsigned floor);
    logic [63:0] top;
    top = (cur_size > 64'hffffffff) ? 64'hffffffff : cur_size;
    if (top < floor || $urandom_range(7) == 0) return $urandom_range(floor + 20);
    return floor + ({$urandom, $urandom} % (top - floor + 1));
  endfunction

  function automatic void build_file(kind_e k, int unsigned len);
    int unsigned total, n, n2, id, ly, seg;
    logic [7:0] b1, b2, c2;
    total = (len < 16 && k != KNoise) ? 16 : len;
    n = 0;
    n2 = 0;
    seg = $urandom_range(12);
    b1 = '0;
    b2 = '0;
    c2 = '0;
    if (k >= KVorbis && k <= KOggBad && total < 35 + seg) total = 35 + seg;
    if (k == KAdts) begin
      n = $urandom_range(9, 80);
      n2 = $urandom_range(9, 60);
      b1 = 8'hf0 | (8'($urandom) & 8'h09);
      b2 = (8'($urandom) & 8'hc3) | 8'($urandom_range(12) << 2);
      c2 = (b2 & 8'hfc) | (8'($urandom) & 8'h03);
    end
    if (k == KMpeg || k == KMpeg3) begin
      do begin
        b1 = {3'b111, ($urandom_range(2) == 0) ? 2'd0 : 2'($urandom_range(2, 3)),
              (k == KMpeg3) ? 2'd1 : 2'($urandom_range(1, 3)), 1'($urandom)};
        b2 = {4'(($urandom_range(4) == 0) ? $urandom_range(1, 14) : $urandom_range(1, 6)),
              2'($urandom_range(2)), 2'($urandom)};
        n = mpeg_frame(8'hff, b1, b2, id, ly);
      end while (n == 0);
      c2 = {4'($urandom_range(1, 6)), b2[3:2], 2'($urandom)};
      n2 = mpeg_frame(8'hff, b1, c2, id, ly);
    end
    if ((k == KAdts || k == KMpeg || k == KMpeg3) && total < n + n2)
      total = n + n2 + $urandom_range(4);
    file_q.delete();
    for (int i = 0; i < total; i++) file_q.push_back(8'($urandom));
    if (total == 0) return;
    case (k)
      KWave: begin
        case ($urandom_range(2))
          0: put_str(0, "RIFF");
          1: put_str(0, "RF64");
          default: put_str(0, "BW64");
        endcase
        put_str(8, "WAVE");
      end
      KRmid: begin put_str(0, "RIFF"); put_str(8, "RMID"); end
      KAu: begin put_str(0, ".snd"); put_word(4, size_field(24)); end
      KAiff: begin put_str(0, "FORM"); put_str(8, $urandom_range(1) ? "AIFF" : "AIFC"); end
      KFlac: begin
        put_str(0, "fLaC");
        put_word(4, {file_q[4] & 8'h80, 24'd34});
      end
      KApe: put_str(0, "MAC ");
      KTta: put_str(0, "TTA1");
      KWavpack: put_str(0, "wvpk");
      KMpc: put_str(0, $urandom_range(1) ? "MPCK" : "MP+");
      KMidi: begin put_str(0, "MThd"); put_word(4, 32'd6); end
      KAmr: put_str(0, "#!AMR\n");
      KAmrWb: put_str(0, "#!AMR-WB\n");
      KMp4: begin put_word(0, size_field(16)); put_str(4, "ftyp"); end
      KAsf: for (int i = 0; i < 16; i++) file_q[i] = GuidAsf[127 - 8 * i -: 8];
      KReal: put_str(0, ".RMF");
      KVorbis, KOpus, KOggFlac, KOggBad: begin
        put_str(0, "OggS");
        file_q[4] = 8'h00;
        file_q[26] = 8'(seg);
        case (k)
          KVorbis: put_str(27 + seg, "\001vorbis");
          KOpus: put_str(27 + seg, "OpusHead");
          KOggFlac: put_str(27 + seg, "\177FLAC");
          default: put_str(27 + seg, "nothings");
        endcase
      end
      KAdts: begin
        file_q[0] = 8'hff;
        file_q[1] = b1;
        file_q[2] = b2;
        file_q[3] = (file_q[3] & 8'hfc) | 8'(n >> 11);
        file_q[4] = 8'(n >> 3);
        file_q[5] = (file_q[5] & 8'h1f) | 8'(n << 5);
        file_q[n] = 8'hff;
        file_q[n + 1] = b1;
        file_q[n + 2] = c2;
        file_q[n + 3] = (file_q[n + 3] & 8'hfc) | 8'(n2 >> 11);
        file_q[n + 4] = 8'(n2 >> 3);
        file_q[n + 5] = (file_q[n + 5] & 8'h1f) | 8'(n2 << 5);
      end
      KMpeg, KMpeg3: begin
        file_q[0] = 8'hff;
        file_q[1] = b1;
        file_q[2] = b2;
        file_q[n] = 8'hff;
        file_q[n + 1] = b1;
        file_q[n + 2] = c2;
      end
      default: ;
    endcase
  endfunction

  task automatic send_file(bit typed, verdict_t typed_v);
    verdict_t v;
    for (int i = 0; i < file_q.size(); i++) begin
      data_byte_i <= file_q[i];
      last_byte_i <= (i == file_q.size() - 1);
      in_valid_i <= 1'b1;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      bytes_sent++;
      if (sniff_byte(file_q[i], i == file_q.size() - 1, v)) verdict_q.push_back(typed ? typed_v : v);
      if ($urandom_range(99) < snd_idle) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
    files_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [63:0] fs, logic [5:0] e);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 1'b0;
    cfg_data_i <= fs;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cur_size = fs;
    cfg_index_i <= 1'b1;
    cfg_data_i <= {$urandom, $urandom_range(67108863), e};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cur_ext = e;
    cfg_valid_i <= 1'b0;
    reg_writes += 2;
  endtask

  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{detected_format_o, suggest_rename_o};
      results_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: format %0d rename %0d",
                                       got.fmt, got.ren);
      end else begin
        want = verdict_q.pop_front();
        if (got.fmt !== want.fmt || got.ren !== want.ren) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected format %0d rename %0d, got format %0d rename %0d",
                     want.fmt, want.ren, got.fmt, got.ren);
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle);
    end
  end

  function automatic logic [63:0] pick_size();
    case ($urandom_range(5))
      0: return 64'd0;
      1: return 64'd41;
      2: return 64'd42;
      3: return '1;
      4: return {$urandom, $urandom};
      default: return 64'($urandom);
    endcase
  endfunction

  function automatic logic [5:0] pick_ext();
    case ($urandom_range(9))
      0: return 6'd0;
      1: return 6'd52;
      2: return 6'd63;
      3, 4, 5: return 6'($urandom_range(63));
      default: return 6'($urandom_range(1, 52));
    endcase
  endfunction

  initial begin
    verdict_t tv;
    kind_e k;
    int unsigned pos;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    out_stall_i = 1'b0;
    cycles = 0;
    mismatches = 0;
    bytes_sent = 0;
    files_sent = 0;
    results_seen = 0;
    reg_writes = 0;
    hold_seq = 0;
    hold_seen = 0;
    hold_left = 0;
    snd_idle = 30;
    rcv_idle = 85;
    cur_size = '0;
    cur_ext = '0;
    clear_stream();
    probes = '{
      '{KNoise, 1, 64'd0, 6'd0, 1, FmtNone, 0},
      '{KWave, 44, 64'd0, 6'd1, 1, FmtWave, 0},
      '{KRmid, 20, 64'd0, 6'd0, 1, FmtRmid, 1},
      '{KAu, 32, '1, 6'd6, 0, FmtNone, 0},
      '{KAiff, 40, 64'd0, 6'd63, 1, FmtAiff, 1},
      '{KFlac, 42, 64'd42, 6'd11, 0, FmtNone, 0},
      '{KFlac, 42, 64'd41, 6'd11, 0, FmtNone, 0},
      '{KApe, 32, 64'd0, 6'd13, 0, FmtNone, 0},
      '{KApe, 31, 64'd0, 6'd14, 0, FmtNone, 0},
      '{KTta, 16, 64'd0, 6'd15, 0, FmtNone, 0},
      '{KWavpack, 31, 64'd0, 6'd16, 0, FmtNone, 0},
      '{KMpc, 20, 64'd0, 6'd18, 0, FmtNone, 0},
      '{KMidi, 22, 64'd0, 6'd20, 0, FmtNone, 0},
      '{KAmr, 16, 64'd0, 6'd23, 0, FmtNone, 0},
      '{KAmrWb, 16, 64'd0, 6'd24, 0, FmtNone, 0},
      '{KMp4, 24, '1, 6'd25, 0, FmtNone, 0},
      '{KAsf, 16, 64'd0, 6'd33, 0, FmtNone, 0},
      '{KReal, 18, 64'd0, 6'd36, 0, FmtNone, 0},
      '{KVorbis, 40, 64'd0, 6'd40, 0, FmtNone, 0},
      '{KOpus, 40, 64'd0, 6'd42, 0, FmtNone, 0},
      '{KOggFlac, 40, 64'd0, 6'd41, 0, FmtNone, 0},
      '{KOggBad, 40, 64'd0, 6'd40, 1, FmtNone, 0},
      '{KAdts, 0, 64'd0, 6'd43, 0, FmtNone, 0},
      '{KMpeg3, 0, 64'd0, 6'd52, 0, FmtNone, 0},
      '{KNoise, BufBytes + 40, 64'd0, 6'd0, 0, FmtNone, 0}};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      set_regs(probes[i].fs, probes[i].ext);
      build_file(probes[i].kind, probes[i].len);
      tv = '{probes[i].fmt, probes[i].ren};
      send_file(probes[i].typed, tv);
    end

    // Long receiver hold while short buffers keep arriving.
    set_regs(64'd1000000, 6'd1);
    hold_seq++;
    for (int i = 0; i < 12; i++) begin
      build_file(kind_e'($urandom_range(KNumKinds - 1)), 16);
      send_file(0, tv);
    end

    for (int phase = 0; phase < 3; phase++) begin
      snd_idle = (phase == 0) ? 30 : (phase == 1) ? 85 : 0;
      rcv_idle = (phase == 0) ? 85 : (phase == 1) ? 30 : 0;
      while (bytes_sent < 2000 + 1200 * (phase + 1) || files_sent < 45 + 30 * (phase + 1)) begin
        if (files_sent % 6 == 0) set_regs(pick_size(), pick_ext());
        k = ($urandom_range(6) == 0) ? KNoise : kind_e'($urandom_range(1, KNumKinds - 1));
        build_file(k, $urandom_range(4) == 0 ? $urandom_range(1, 60) : $urandom_range(16, 40));
        if ($urandom_range(3) == 0 && file_q.size() != 0) begin
          pos = $urandom_range((file_q.size() > 40) ? 39 : file_q.size() - 1);
          file_q[pos][$urandom_range(7)] ^= 1'b1;
        end
        if ($urandom_range(9) == 0)
          while (file_q.size() > 1 && $urandom_range(3) != 0) void'(file_q.pop_back());
        send_file(0, tv);
      end
    end

    drain();
    $display("Covered %0d header buffers, %0d bytes and %0d register writes", files_sent,
             bytes_sent, reg_writes);
    $display("under three idle patterns and a long output hold; %0d results, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### audio_container_sniffer_unit.f
rtl/acs_pkg.sv
rtl/acs_frame_div.sv
rtl/audio_container_sniffer_unit.sv
verif/testbench.sv
